// File: sv/ocaa_pkg.sv
// Shared types, widths, constants and the octant pivot table for the octant angle core.
package ocaa_pkg;

	localparam int COORD_W   = 16;
	localparam int FRAC_BITS = 7;
	localparam int ANGLE_W   = 16;
	localparam int THR_W     = 15;

	// pivots in signed Q1.16: 1.0 and sqrt(2)/2 rounded
	localparam int PIV_ONE = 65536;
	localparam int PIV_R   = 46341;
	localparam int PIV_W   = 18;
	localparam int DEG_W   = 9;

	localparam int PROD_W = COORD_W + PIV_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int MAG_W  = SUM_W - 1;

	localparam int K_DEG   = 45;
	localparam int K_SCALE = K_DEG << FRAC_BITS;
	localparam int QUO_W   = $clog2(K_SCALE + 1);
	localparam int NUM_W   = MAG_W + QUO_W;

	localparam logic signed [PIV_W-1:0] P_ONE = PIV_W'(PIV_ONE);
	localparam logic signed [PIV_W-1:0] P_R   = PIV_W'(PIV_R);
	localparam logic signed [PIV_W-1:0] P_ZERO = '0;

	typedef enum logic [2:0] {
		OCT_0 = 3'd0,
		OCT_1 = 3'd1,
		OCT_2 = 3'd2,
		OCT_3 = 3'd3,
		OCT_4 = 3'd4,
		OCT_5 = 3'd5,
		OCT_6 = 3'd6,
		OCT_7 = 3'd7
	} oct_t;

	// pivot a, chord direction d = a - b, octant base angle in degrees
	typedef struct packed {
		logic signed [PIV_W-1:0] ax;
		logic signed [PIV_W-1:0] ay;
		logic signed [PIV_W-1:0] dx;
		logic signed [PIV_W-1:0] dy;
		logic signed [DEG_W-1:0] shift;
	} piv_t;

	// sideband that rides along with the divider
	typedef struct packed {
		logic               kill;
		logic               neg;
		logic [ANGLE_W-1:0] base;
	} side_t;

	function automatic piv_t oct_piv(input oct_t o);
		piv_t p;
		p = '0;
		unique case (o)
			OCT_0: begin
				p.ax = P_ONE;  p.ay = P_ZERO;
				p.dx = P_ONE - P_R;  p.dy = -P_R;
				p.shift = DEG_W'(0);
			end
			OCT_1: begin
				p.ax = P_R;  p.ay = P_R;
				p.dx = P_R;  p.dy = P_R - P_ONE;
				p.shift = DEG_W'(45);
			end
			OCT_2: begin
				p.ax = P_ZERO;  p.ay = P_ONE;
				p.dx = P_R;  p.dy = P_ONE - P_R;
				p.shift = DEG_W'(90);
			end
			OCT_3: begin
				p.ax = -P_R;  p.ay = P_R;
				p.dx = P_ONE - P_R;  p.dy = P_R;
				p.shift = DEG_W'(135);
			end
			OCT_4: begin
				p.ax = -P_ONE;  p.ay = P_ZERO;
				p.dx = P_R - P_ONE;  p.dy = P_R;
				p.shift = DEG_W'(-180);
			end
			OCT_5: begin
				p.ax = -P_R;  p.ay = -P_R;
				p.dx = -P_R;  p.dy = P_ONE - P_R;
				p.shift = DEG_W'(-135);
			end
			OCT_6: begin
				p.ax = P_ZERO;  p.ay = -P_ONE;
				p.dx = -P_R;  p.dy = P_R - P_ONE;
				p.shift = DEG_W'(-90);
			end
			OCT_7: begin
				p.ax = P_R;  p.ay = -P_R;
				p.dx = P_R - P_ONE;  p.dy = -P_R;
				p.shift = DEG_W'(-45);
			end
		endcase
		return p;
	endfunction

endpackage

// File: sv/ocaa_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband carried along.
module ocaa_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [ocaa_pkg::NUM_W-1:0]   in_num,
	input  logic [ocaa_pkg::MAG_W-1:0]   in_den,
	input  ocaa_pkg::side_t              in_side,
	output logic                         out_vld,
	output logic [ocaa_pkg::QUO_W-1:0]   out_quo,
	output ocaa_pkg::side_t              out_side
);
	import ocaa_pkg::*;

	logic             vld_s  [QUO_W];
	logic [NUM_W-1:0] rem_s  [QUO_W];
	logic [MAG_W-1:0] den_s  [QUO_W];
	logic [QUO_W-1:0] quo_s  [QUO_W];
	side_t            side_s [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		localparam int B = QUO_W - 1 - i;

		logic             v_in;
		logic [NUM_W-1:0] r_in;
		logic [MAG_W-1:0] d_in;
		logic [QUO_W-1:0] q_in;
		side_t            s_in;
		logic [NUM_W-1:0] sub;
		logic             ge;

		if (i == 0) begin : g_head
			assign v_in = in_vld;
			assign r_in = in_num;
			assign d_in = in_den;
			assign q_in = '0;
			assign s_in = in_side;
		end else begin : g_tail
			assign v_in = vld_s[i-1];
			assign r_in = rem_s[i-1];
			assign d_in = den_s[i-1];
			assign q_in = quo_s[i-1];
			assign s_in = side_s[i-1];
		end

		assign sub = NUM_W'(d_in) << B;
		assign ge  = (r_in >= sub);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? (r_in - sub) : r_in;
				den_s[i]  <= d_in;
				quo_s[i]  <= q_in | (QUO_W'(ge) << B);
				side_s[i] <= s_in;
			end
		end
	end

	assign out_vld  = vld_s[QUO_W-1];
	assign out_quo  = quo_s[QUO_W-1];
	assign out_side = side_s[QUO_W-1];

`ifndef NO_ASSERTIONS
	// numerator was clamped to the divisor, so the quotient never exceeds the scale
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld && !out_side.kill) |-> (out_quo <= QUO_W'(K_SCALE)))
		else $error("quotient above scale");

	a_rem_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld && !out_side.kill) |-> (rem_s[QUO_W-1] < NUM_W'(den_s[QUO_W-1])))
		else $error("division remainder not reduced");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && out_vld) |=> (out_vld && $stable(out_quo) && $stable(out_side)))
		else $error("divider output moved while stalled");
`endif

endmodule

// File: sv/octant_chord_angle_approximation_core.sv
// Top level of the octant chord angle core: octant select, cross products, divider, output word.
//
// Input stream: s_axis_tdata carries x_coord in [15:0] and y_coord in [31:16], both
// two's complement. Output stream: m_axis_tdata carries angle in 1/128 degree units,
// two's complement, over [-180,180] degrees. One output word per input word, in order.
// cfg_wr_en/cfg_wr_data write zero_threshold; write it only while the core is idle.
// Points with |x| and |y| both at or below the threshold give angle 0.
// Throughput: one word per cycle while not stalled. Stages from input accept to m_axis_tvalid:
// five front stages (octant select, products, differences, magnitudes, scaling), one
// stage per quotient bit of the 13-bit restoring divider, and the output register.
// When the receiver holds m_axis_tready low with a word waiting, the whole pipeline
// freezes and s_axis_tready drops; nothing is lost or repeated. Bubbles pass freely.
// Reset clears all valid bits and sets zero_threshold to 0.
module octant_chord_angle_approximation_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [ocaa_pkg::THR_W-1:0]    cfg_wr_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [31:0]                   s_axis_tdata,   // x_coord, y_coord
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata    // angle
);
	import ocaa_pkg::*;

	logic               en;
	logic [THR_W-1:0]   thr_q;

	// stage 0 comb
	logic signed [COORD_W-1:0] x_in, y_in;
	logic signed [COORD_W:0]   x_e, y_e;
	logic [COORD_W:0]          x_abs, y_abs;
	logic                      near;
	oct_t                      oct;

	// stage 1
	logic                      vld_s1;
	logic signed [COORD_W-1:0] px_s1, py_s1;
	oct_t                      oct_s1;
	logic                      near_s1;
	piv_t                      piv;

	// stage 2
	logic                      vld_s2;
	logic signed [PROD_W-1:0]  pa_s2, pb_s2, pc_s2, pd_s2;
	logic [ANGLE_W-1:0]        base_s2;
	logic                      near_s2;

	// stage 3
	logic                      vld_s3;
	logic signed [SUM_W-1:0]   num_s3, den_s3;
	logic [ANGLE_W-1:0]        base_s3;
	logic                      near_s3;
	logic                      num_neg, den_neg;
	logic [SUM_W-1:0]          num_abs, den_abs;
	logic [MAG_W-1:0]          n_mag, d_mag;

	// stage 4
	logic                      vld_s4;
	logic [MAG_W-1:0]          n_s4, d_s4;
	side_t                     side_s4;
	logic [NUM_W-1:0]          n_ext;

	// stage 5, divider input
	logic                      vld_s5;
	logic [NUM_W-1:0]          nk_s5;
	logic [MAG_W-1:0]          d_s5;
	side_t                     side_s5;

	// divider output
	logic                      div_vld;
	logic [QUO_W-1:0]          div_quo;
	side_t                     div_side;
	logic [ANGLE_W-1:0]        q_w, part;

	logic                      out_vld_q;
	logic [ANGLE_W-1:0]        angle_q;

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// octant select and near-origin test
	assign x_in  = s_axis_tdata[COORD_W-1:0];
	assign y_in  = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign x_e   = (COORD_W+1)'(x_in);
	assign y_e   = (COORD_W+1)'(y_in);
	assign x_abs = x_e[COORD_W] ? -x_e : x_e;
	assign y_abs = y_e[COORD_W] ? -y_e : y_e;
	assign near  = (x_abs <= (COORD_W+1)'(thr_q)) && (y_abs <= (COORD_W+1)'(thr_q));

	always_comb begin
		if (!y_e[COORD_W]) begin
			if (!x_e[COORD_W]) oct = (y_e <= x_e) ? OCT_0 : OCT_1;
			else               oct = (y_e > -x_e) ? OCT_2 : OCT_3;
		end else begin
			if (x_e[COORD_W])  oct = (y_e >= x_e) ? OCT_4 : OCT_5;
			else               oct = (-y_e > x_e) ? OCT_6 : OCT_7;
		end
	end

	assign piv = oct_piv(oct_s1);

	// fraction = cross(p, a) / cross(p, a - b)
	assign num_neg = num_s3[SUM_W-1];
	assign den_neg = den_s3[SUM_W-1];
	assign num_abs = num_neg ? -num_s3 : num_s3;
	assign den_abs = den_neg ? -den_s3 : den_s3;
	assign d_mag   = MAG_W'(den_abs);
	assign n_mag   = (MAG_W'(num_abs) > d_mag) ? d_mag : MAG_W'(num_abs);

	// n * 45 * 2^F as shifts and adds
	assign n_ext = NUM_W'(n_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= s_axis_tvalid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			out_vld_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= x_in;
			py_s1   <= y_in;
			oct_s1  <= oct;
			near_s1 <= near;

			pa_s2   <= px_s1 * piv.ay;
			pb_s2   <= py_s1 * piv.ax;
			pc_s2   <= px_s1 * piv.dy;
			pd_s2   <= py_s1 * piv.dx;
			base_s2 <= ANGLE_W'(piv.shift) << FRAC_BITS;
			near_s2 <= near_s1;

			num_s3  <= SUM_W'(pa_s2) - SUM_W'(pb_s2);
			den_s3  <= SUM_W'(pc_s2) - SUM_W'(pd_s2);
			base_s3 <= base_s2;
			near_s3 <= near_s2;

			n_s4         <= n_mag;
			d_s4         <= d_mag;
			side_s4.kill <= near_s3 || (den_s3 == '0);
			side_s4.neg  <= num_neg ^ den_neg;
			side_s4.base <= near_s3 ? '0 : base_s3;

			nk_s5   <= ((n_ext << 5) + (n_ext << 3) + (n_ext << 2) + n_ext) << FRAC_BITS;
			d_s5    <= d_s4;
			side_s5 <= side_s4;

			angle_q <= div_side.base + part;
		end
	end

	ocaa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s5),
		.in_num   (nk_s5),
		.in_den   (d_s5),
		.in_side  (side_s5),
		.out_vld  (div_vld),
		.out_quo  (div_quo),
		.out_side (div_side)
	);

	assign q_w  = ANGLE_W'(div_quo);
	assign part = div_side.kill ? '0 : (div_side.neg ? -q_w : q_w);

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = angle_q;

endmodule

// File: dv/octant_angle_checker.sv
// Stream monitor for the octant angle core: predicts each angle from the accepted point, checks in order.
`timescale 1ns / 1ps
module octant_angle_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ocaa_pkg::THR_W-1:0] cfg_wr_data,
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	input  logic [31:0]                s_axis_tdata,   // x_coord, y_coord
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [15:0]                m_axis_tdata,   // angle
	output int                         angles_due,
	output int                         angles_checked,
	output int                         fail_count
);
	import ocaa_pkg::*;

	localparam longint UNIT = PIV_ONE;
	localparam longint HALF_RT2 = PIV_R;

	logic [ANGLE_W-1:0] angle_due_q [$];
	logic [THR_W-1:0]   thr_seen;
	int                 n_fail = 0;
	int                 n_checked = 0;

	function automatic logic [ANGLE_W-1:0] predict_angle(
		input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y,
		input logic [THR_W-1:0]          thr
	);
		longint px, py, ax, ay, bx, by, deg;
		longint num, den, n, d, q, part;
		oct_t   oct;
		logic   neg;
		px = x;
		py = y;
		if ((px < 0 ? -px : px) <= longint'(thr) && (py < 0 ? -py : py) <= longint'(thr))
			return '0;

		if (py >= 0) begin
			if (px >= 0) oct = (py <= px) ? OCT_0 : OCT_1;
			else         oct = (py > -px) ? OCT_2 : OCT_3;
		end else begin
			if (px < 0)  oct = (py >= px) ? OCT_4 : OCT_5;
			else         oct = (-py > px) ? OCT_6 : OCT_7;
		end

		// pivot a, pivot b, base angle in degrees
		case (oct)
			OCT_0: begin ax = UNIT;      ay = 0;         bx = HALF_RT2;  by = HALF_RT2;  deg = 0;    end
			OCT_1: begin ax = HALF_RT2;  ay = HALF_RT2;  bx = 0;         by = UNIT;      deg = 45;   end
			OCT_2: begin ax = 0;         ay = UNIT;      bx = -HALF_RT2; by = HALF_RT2;  deg = 90;   end
			OCT_3: begin ax = -HALF_RT2; ay = HALF_RT2;  bx = -UNIT;     by = 0;         deg = 135;  end
			OCT_4: begin ax = -UNIT;     ay = 0;         bx = -HALF_RT2; by = -HALF_RT2; deg = -180; end
			OCT_5: begin ax = -HALF_RT2; ay = -HALF_RT2; bx = 0;         by = -UNIT;     deg = -135; end
			OCT_6: begin ax = 0;         ay = -UNIT;     bx = HALF_RT2;  by = -HALF_RT2; deg = -90;  end
			default: begin ax = HALF_RT2; ay = -HALF_RT2; bx = UNIT;     by = 0;         deg = -45;  end
		endcase

		num = px * ay - py * ax;
		den = px * (ay - by) - py * (ax - bx);
		part = 0;
		if (den != 0) begin
			neg = (num < 0) != (den < 0);
			n = (num < 0) ? -num : num;
			d = (den < 0) ? -den : den;
			if (n > d)
				n = d;
			q = (n * K_SCALE) / d;   // truncates toward zero
			part = neg ? -q : q;
		end
		return ANGLE_W'(deg * (64'sd1 << FRAC_BITS) + part);
	endfunction

	always @(posedge clk) begin
		logic [ANGLE_W-1:0] want;
		if (!arst_n) begin
			thr_seen = '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				angle_due_q.push_back(predict_angle(s_axis_tdata[15:0], s_axis_tdata[31:16],
					thr_seen));
			if (m_axis_tvalid && m_axis_tready) begin
				if (angle_due_q.size() == 0) begin
					$error("angle: word with nothing expected, actual %0d",
						$signed(m_axis_tdata));
					n_fail++;
				end else begin
					want = angle_due_q.pop_front();
					if (m_axis_tdata !== want) begin
						$error("angle: expected %0d, actual %0d", $signed(want),
							$signed(m_axis_tdata));
						n_fail++;
					end
					n_checked++;
				end
			end
			if (cfg_wr_en)
				thr_seen = cfg_wr_data;
		end
		angles_due <= angle_due_q.size();
		angles_checked <= n_checked;
		fail_count <= n_fail;
	end

endmodule

// File: dv/tb_octant_chord_angle_approximation_core.sv
// Testbench top for the octant angle core: clock, reset, point stimulus, threshold writes, verdict.
`timescale 1ns / 1ps
module tb_octant_chord_angle_approximation_core;
	import ocaa_pkg::*;

	localparam int HOLD_CYCLES = 150;
	localparam int TAIL_CYCLES = 30;
	localparam int STALL_LIMIT = 2000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [THR_W-1:0] cfg_wr_data = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [31:0]      s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [15:0]      m_axis_tdata;

	int               angles_due;
	int               angles_checked;
	int               fail_count;

	bit               steady = 1'b0;
	bit               hold_req = 1'b0;
	int               points_sent = 0;
	int               settings_used = 0;
	logic [THR_W-1:0] thr_now = '0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	octant_chord_angle_approximation_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	octant_angle_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.angles_due     (angles_due),
		.angles_checked (angles_checked),
		.fail_count     (fail_count)
	);

	// watchdog: ends the run if no word moves on either side for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = steady ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {y, x};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		points_sent++;
	endtask

	// stop offering and wait until every predicted angle has come back
	task automatic drain_all();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (angles_due != 0);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] v);
		drain_all();
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		thr_now = v;
		settings_used++;
	endtask

	function automatic logic signed [15:0] pick_coord();
		logic signed [15:0] c;
		case ($urandom_range(0, 9))
			0: c = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1, 2: begin
				// straddle the zero threshold
				c = 16'(int'(thr_now) + int'($urandom_range(0, 3)) - 1);
				if ($urandom_range(0, 1))
					c = -c;
			end
			3: c = 16'(int'($urandom_range(0, 128)) - 64);
			default: c = 16'($urandom);
		endcase
		return c;
	endfunction

	task automatic send_random_point();
		logic signed [15:0] x, y, t;
		x = pick_coord();
		case ($urandom_range(0, 5))
			0: y = x + 16'($urandom_range(0, 4)) - 16'sd2;       // near the x = y diagonal
			1: y = -x + 16'($urandom_range(0, 4)) - 16'sd2;      // near the x = -y diagonal
			2: y = 16'($urandom_range(0, 2)) - 16'sd1;           // near an axis
			default: y = pick_coord();
		endcase
		if ($urandom_range(0, 1)) begin
			t = x;
			x = y;
			y = t;
		end
		send_point(x, y);
	endtask

	initial begin
		logic [THR_W-1:0] thr;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// threshold at reset value: origin, axis extremes, corners, one point per octant
		send_point(0, 0);
		send_point(32767, 0);
		send_point(-32768, 0);
		send_point(0, 32767);
		send_point(0, -32768);
		send_point(32767, 32767);
		send_point(-32768, 32767);
		send_point(-32768, -32768);
		send_point(32767, -32768);
		send_point(1, -1);
		send_point(7, 3);
		send_point(3, 7);
		send_point(-3, 7);
		send_point(-7, 3);
		send_point(-7, -3);
		send_point(-3, -7);
		send_point(3, -7);
		send_point(7, -3);

		write_threshold(15'd100);
		send_point(100, -100);
		send_point(101, 0);
		send_point(-100, 100);
		send_point(0, -101);

		write_threshold(15'h7FFF);
		send_point(32767, -32767);
		send_point(-32768, 5);
		send_point(3, -32768);

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: thr = '0;
				1: thr = 15'h7FFF;
				2: thr = 15'd1;
				3: thr = 15'($urandom_range(2, 64));
				7: thr = 15'($urandom);
				default: thr = 15'($urandom_range(0, 2000));
			endcase
			write_threshold(thr);
			steady = (phase == 1 || phase == 5);
			if (phase == 2) begin
				// receiver stalls long while points keep coming at full rate
				hold_req = 1'b1;
				steady = 1'b1;
				repeat (40) send_random_point();
				steady = 1'b0;
			end
			if (phase == 4) begin
				repeat (45) send_random_point();
				drain_all();
			end
			repeat (85) send_random_point();
		end
		steady = 1'b0;

		drain_all();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d points under %0d threshold writes; %0d angles compared in order.",
			points_sent, settings_used, angles_checked);
		$display("Covered all octants, diagonals, axes, extremes and near-threshold points.");
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: octant_chord_angle_approximation_core.f
sv/ocaa_pkg.sv
sv/ocaa_div.sv
sv/octant_chord_angle_approximation_core.sv
dv/octant_angle_checker.sv
dv/tb_octant_chord_angle_approximation_core.sv
